>>> hw/rtl/fbfl_pkg.sv
// Shared types and constants for the fixed-block free-list allocator.
// Used by the controller, the datapath and the top level.
package fbfl_pkg;

	localparam int OPCODE_W  = 2;
	localparam int DATA_W    = 32;
	localparam int STATUS_W  = 2;
	localparam int SIZE_W    = 17;
	localparam int COUNT_W   = 11;
	localparam int CFG_IDX_W = 2;
	// rounded block size plus block header fits in 18 bits
	localparam int STR_W     = 18;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 72;

	localparam int REGION_HDR = 12;
	localparam int BLOCK_HDR  = 8;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INIT  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2
	} op_e_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_BAD_ADDR = 2'd2
	} status_e_t;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT  = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic accept;      // latch the input item
		logic calc;        // stride products, offset, link read at head
		logic init_step;   // write one link of the init chain
		logic free_check;  // range check, load divider
		logic div_step;    // one quotient bit
		logic finish;      // commit state, load output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [OPCODE_W-1:0] op;
		logic                count_zero;
		logic                init_last;
		logic                out_range;
		logic                div_last;
		logic                out_free;
	} sts_t;

endpackage

>>> hw/rtl/fbfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fbfl_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/fbfl_ctrl.sv
// Sequencing state machine of the allocator.
// Depends on fbfl_pkg; drives the datapath through cmd_t, watches sts_t.
module fbfl_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  fbfl_pkg::sts_t sts,
	output fbfl_pkg::cmd_t cmd
);
	import fbfl_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CALC,
		S_INIT,
		S_RANGE,
		S_DIV,
		S_FIN
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) state_q <= S_CALC;
				end
				S_CALC: begin
					if (sts.op == OP_INIT && !sts.count_zero) state_q <= S_INIT;
					else if (sts.op == OP_FREE) state_q <= S_RANGE;
					else state_q <= S_FIN;
				end
				S_INIT: begin
					if (sts.init_last) state_q <= S_FIN;
				end
				S_RANGE: begin
					if (sts.out_range) state_q <= S_FIN;
					else state_q <= S_DIV;
				end
				S_DIV: begin
					if (sts.div_last) state_q <= S_FIN;
				end
				S_FIN: begin
					// hold until the output register can take the result
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.accept     = (state_q == S_IDLE) && s_tvalid;
		cmd.calc       = (state_q == S_CALC);
		cmd.init_step  = (state_q == S_INIT);
		cmd.free_check = (state_q == S_RANGE);
		cmd.div_step   = (state_q == S_DIV);
		cmd.finish     = (state_q == S_FIN) && sts.out_free;
	end

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.calc, cmd.init_step, cmd.free_check,
			cmd.div_step, cmd.finish}))
		else $error("controller issued two commands at once");

	a_accept_calc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == S_CALC)
		else $error("accepted item did not start work");

	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> s_tready)
		else $error("not ready after finishing an item");

endmodule

>>> hw/rtl/fbfl_dp.sv
// Datapath of the allocator: config registers, free-list head, link RAM,
// address arithmetic, offset divider and output register.
// Depends on fbfl_pkg and fbfl_ram.
module fbfl_dp #(
	parameter int MAX_BLOCKS = 1024,
	parameter int ADDR_BITS  = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fbfl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fbfl_pkg::DATA_W-1:0]    cfg_wdata,
	input  logic [fbfl_pkg::OPCODE_W-1:0]  in_opcode,
	input  logic [fbfl_pkg::DATA_W-1:0]    in_free_address,
	input  logic                           m_tready,
	input  fbfl_pkg::cmd_t                 cmd,
	output fbfl_pkg::sts_t                 sts,
	output logic                           out_valid,
	output logic [fbfl_pkg::DATA_W-1:0]    out_result_address,
	output logic [fbfl_pkg::DATA_W-1:0]    out_total_size,
	output logic [fbfl_pkg::STATUS_W-1:0]  out_status
);
	import fbfl_pkg::*;

	localparam int AW     = $clog2(MAX_BLOCKS);
	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam int SPAN_W = CNT_W + STR_W;
	localparam int EXT_W  = ADDR_BITS + SPAN_W;
	localparam int TOT_W  = SPAN_W + 1;
	localparam int MUL_W  = AW + STR_W;
	localparam int KW     = $clog2(AW) + 1;
	localparam logic [CNT_W-1:0] NULL_IDX = CNT_W'(MAX_BLOCKS);

	// config
	logic [DATA_W-1:0]  base_q;
	logic [SIZE_W-1:0]  size_q;
	logic [COUNT_W-1:0] count_q;

	// control state
	logic [CNT_W-1:0] head_q;
	logic             out_valid_q;

	// payload
	logic [OPCODE_W-1:0]  op_q;
	logic [DATA_W-1:0]    faddr_q;
	logic [SPAN_W-1:0]    span_q;
	logic [MUL_W-1:0]     mul_q;
	logic [ADDR_BITS-1:0] off_q;
	logic [CNT_W-1:0]     i_q;
	logic [SPAN_W-1:0]    rem_q;
	logic [SPAN_W-1:0]    dvs_q;
	logic [AW-1:0]        q_q;
	logic [KW-1:0]        k_q;
	logic                 bad_q;
	logic [DATA_W-1:0]    res_addr_q;
	logic [DATA_W-1:0]    res_total_q;
	logic [STATUS_W-1:0]  res_status_q;

	logic [STR_W-1:0]     rnd_c;
	logic [STR_W-1:0]     stride_c;
	logic [CNT_W-1:0]     eff_c;
	logic [CNT_W-1:0]     i_nxt_c;
	logic [CNT_W-1:0]     init_link_c;
	logic [ADDR_BITS-1:0] base_ab_c;
	logic [ADDR_BITS-1:0] payload_c;
	logic                 ge_c;
	logic                 free_ok_c;
	logic                 out_free_c;
	logic [CNT_W-1:0]     link_rd;
	logic [CNT_W-1:0]     alloc_head_c;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [CNT_W-1:0]     ram_wdata;
	logic [DATA_W-1:0]    res_addr_c;
	logic [DATA_W-1:0]    res_total_c;
	logic [STATUS_W-1:0]  res_status_c;

	assign rnd_c    = (STR_W'(size_q) + STR_W'(7)) & ~STR_W'(7);
	assign stride_c = rnd_c + STR_W'(BLOCK_HDR);

	always_comb begin
		if (32'(count_q) > 32'(MAX_BLOCKS)) eff_c = NULL_IDX;
		else eff_c = CNT_W'(count_q);
	end

	assign i_nxt_c     = i_q + CNT_W'(1);
	assign init_link_c = (i_nxt_c < eff_c) ? i_nxt_c : NULL_IDX;
	assign base_ab_c   = ADDR_BITS'(base_q);
	assign payload_c   = base_ab_c + ADDR_BITS'(REGION_HDR + BLOCK_HDR) + ADDR_BITS'(mul_q);
	assign ge_c        = rem_q >= dvs_q;
	assign free_ok_c   = !bad_q && (rem_q == '0);
	assign out_free_c  = !out_valid_q || m_tready;
	// clamp a link that points past the end to the empty marker
	assign alloc_head_c = (link_rd >= NULL_IDX) ? NULL_IDX : link_rd;

	assign ram_we    = cmd.init_step || (cmd.finish && op_q == OP_FREE && free_ok_c);
	assign ram_waddr = cmd.init_step ? i_q[AW-1:0] : q_q;
	assign ram_wdata = cmd.init_step ? init_link_c : head_q;

	fbfl_ram #(
		.WIDTH (CNT_W),
		.DEPTH (MAX_BLOCKS)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.calc),
		.raddr (head_q[AW-1:0]),
		.rdata (link_rd)
	);

	always_comb begin
		res_addr_c   = '0;
		res_total_c  = '0;
		res_status_c = ST_OK;
		case (op_q)
			OP_INIT: begin
				res_addr_c  = DATA_W'(base_ab_c);
				res_total_c = DATA_W'(TOT_W'(span_q) + TOT_W'(REGION_HDR));
			end
			OP_ALLOC: begin
				if (head_q == NULL_IDX) res_status_c = ST_EMPTY;
				else res_addr_c = DATA_W'(payload_c);
			end
			OP_FREE: begin
				if (free_ok_c) res_addr_c = DATA_W'(base_ab_c);
				else res_status_c = ST_BAD_ADDR;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			size_q      <= SIZE_W'(8);
			count_q     <= COUNT_W'(1);
			head_q      <= NULL_IDX;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BASE_ADDRESS: base_q  <= cfg_wdata;
					REG_BLOCK_SIZE:   size_q  <= cfg_wdata[SIZE_W-1:0];
					REG_BLOCK_COUNT:  count_q <= cfg_wdata[COUNT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.finish) begin
				case (op_q)
					OP_INIT:  head_q <= (eff_c == '0) ? NULL_IDX : '0;
					OP_ALLOC: if (head_q != NULL_IDX) head_q <= alloc_head_c;
					OP_FREE:  if (free_ok_c) head_q <= CNT_W'(q_q);
					default: ;
				endcase
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= in_opcode;
			faddr_q <= in_free_address;
		end
		if (cmd.calc) begin
			span_q <= SPAN_W'(eff_c) * SPAN_W'(stride_c);
			mul_q  <= MUL_W'(head_q[AW-1:0]) * MUL_W'(stride_c);
			off_q  <= ADDR_BITS'(faddr_q) - base_ab_c - ADDR_BITS'(REGION_HDR + BLOCK_HDR);
			i_q    <= '0;
		end
		if (cmd.init_step) begin
			i_q <= i_nxt_c;
		end
		if (cmd.free_check) begin
			bad_q <= EXT_W'(off_q) >= EXT_W'(span_q);
			rem_q <= SPAN_W'(off_q);
			dvs_q <= SPAN_W'(stride_c) << (AW - 1);
			q_q   <= '0;
			k_q   <= KW'(AW - 1);
		end
		if (cmd.div_step) begin
			if (ge_c) rem_q <= rem_q - dvs_q;
			q_q   <= (q_q << 1) | AW'(ge_c);
			dvs_q <= dvs_q >> 1;
			k_q   <= k_q - KW'(1);
		end
		if (cmd.finish) begin
			res_addr_q   <= res_addr_c;
			res_total_q  <= res_total_c;
			res_status_q <= res_status_c;
		end
	end

	always_comb begin
		sts            = '0;
		sts.op         = op_q;
		sts.count_zero = (eff_c == '0);
		sts.init_last  = (i_nxt_c == eff_c);
		sts.out_range  = EXT_W'(off_q) >= EXT_W'(span_q);
		sts.div_last   = (k_q == '0);
		sts.out_free   = out_free_c;
	end

	assign out_valid          = out_valid_q;
	assign out_result_address = res_addr_q;
	assign out_total_size     = res_total_q;
	assign out_status         = res_status_q;

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= NULL_IDX)
		else $error("free-list head beyond the empty marker");

	a_fin_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> out_free_c)
		else $error("result overwrote an item not yet taken");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> ({1'b0, rem_q} < {dvs_q, 1'b0}))
		else $error("divider remainder out of range for quotient bit");

endmodule

>>> hw/rtl/fixed_block_free_list_allocator.sv
// Top level of the fixed-block free-list allocator.
// Depends on fbfl_pkg, fbfl_ctrl, fbfl_dp (and fbfl_ram inside fbfl_dp).
//
// Usage:
//   Write base_address (index 0), block_size (1) and block_count (2) on the
//   cfg port while the block is idle. Send one item per request on s_axis:
//   opcode init, alloc or free, with the payload address for free. Each item
//   gives exactly one result on m_axis: result address, total size, status.
// Steps per item: accept, then calc (stride products, offset, link RAM read
//   at the head); alloc and the unused opcode then finish. free adds a range
//   check and then the one-bit-per-cycle divider that turns the byte offset
//   into a block index; the divider is skipped when the address lies past
//   the end of the region. init adds one link RAM write per block of the
//   effective block count. The finish step loads the output register and
//   raises m_axis_tvalid.
// Reset: registers return to base 0, size 8, count 1; the free list is
//   empty, so an alloc before any init reports no free block. The link RAM
//   is not cleared.
// Stall: a result waits in the output register; the next item is accepted
//   and worked on, and holds in its last step until the register is free.
module fixed_block_free_list_allocator #(
	parameter int MAX_BLOCKS = 1024,
	parameter int ADDR_BITS  = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fbfl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fbfl_pkg::DATA_W-1:0]     cfg_wdata,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// opcode [1:0], free_address [33:2], zero [39:34]
	input  logic [fbfl_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// result_address [31:0], total_size [63:32], status [65:64], zero [71:66]
	output logic [fbfl_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
	import fbfl_pkg::*;

	cmd_t                cmd;
	sts_t                sts;
	logic [DATA_W-1:0]   res_addr;
	logic [DATA_W-1:0]   res_total;
	logic [STATUS_W-1:0] res_status;

	fbfl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fbfl_dp #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.ADDR_BITS  (ADDR_BITS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_wdata          (cfg_wdata),
		.in_opcode          (s_axis_tdata[OPCODE_W-1:0]),
		.in_free_address    (s_axis_tdata[OPCODE_W+DATA_W-1:OPCODE_W]),
		.m_tready           (m_axis_tready),
		.cmd                (cmd),
		.sts                (sts),
		.out_valid          (m_axis_tvalid),
		.out_result_address (res_addr),
		.out_total_size     (res_total),
		.out_status         (res_status)
	);

	assign m_axis_tdata = {(M_TDATA_W - 2*DATA_W - STATUS_W)'(0), res_status, res_total, res_addr};

endmodule
